/* design/hpst_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and helpers for the hop probe statistics table.
// No dependencies.
package hpst_pkg;

  localparam int HOP_DEPTH_DEF = 32;

  localparam logic [2:0] FUNC_REPLY     = 3'd0;
  localparam logic [2:0] FUNC_FAIL      = 3'd1;
  localparam logic [2:0] FUNC_READ      = 3'd2;
  localparam logic [2:0] FUNC_CLR_STATS = 3'd3;
  localparam logic [2:0] FUNC_CLR_ALL   = 3'd4;

  // One hop's statistics record, as kept in the stats memory.
  typedef struct packed {
    logic [31:0] sent;
    logic [31:0] reply;
    logic [15:0] best;
    logic [15:0] worst;
    logic [15:0] last;
    logic [31:0] total;
    logic [31:0] jitter;
    logic [31:0] acnt;
    logic [31:0] acode;
  } stats_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

/* design/hpst_rec_mem.sv */
`timescale 1ns / 1ps
// Per-hop record memory: one write port, one registered read port, and a
// valid bit per entry so that a clear empties all entries together. Uses hpst_pkg.
module hpst_rec_mem #(
  parameter int WIDTH = 32,
  parameter int DEPTH = hpst_pkg::HOP_DEPTH_DEF,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clr,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [WIDTH-1:0] rd_q;
  logic             rd_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q  <= mem[rd_idx];
      rd_ok <= vld[rd_idx];
    end
  end

  // an entry never written since the last clear reads as zero
  assign rd_data = rd_ok ? rd_q : '0;

endmodule

/* design/hpst_update.sv */
`timescale 1ns / 1ps
// Read-modify-write arithmetic for one hop record: reply and failure updates
// with saturating counters. Uses hpst_pkg.
module hpst_update (
  input  logic            is_reply,
  input  logic            is_fail,
  input  logic [15:0]     rtt,
  input  logic [31:0]     code,
  input  hpst_pkg::stats_t old_rec,
  output hpst_pkg::stats_t new_rec
);

  logic [15:0] diff;

  always_comb begin
    new_rec = old_rec;
    diff    = (rtt > old_rec.last) ? (rtt - old_rec.last) : (old_rec.last - rtt);
    if (is_reply || is_fail) begin
      new_rec.sent = hpst_pkg::sat_add(old_rec.sent, 32'd1);
    end
    if (is_reply) begin
      // jitter only once a previous reply exists
      if (old_rec.reply != 32'd0) begin
        new_rec.jitter = hpst_pkg::sat_add(old_rec.jitter, {16'd0, diff});
      end
      new_rec.last  = rtt;
      new_rec.total = hpst_pkg::sat_add(old_rec.total, {16'd0, rtt});
      if (old_rec.reply == 32'd0 || old_rec.best > rtt) begin
        new_rec.best = rtt;
      end
      if (old_rec.worst < rtt) begin
        new_rec.worst = rtt;
      end
      new_rec.reply = hpst_pkg::sat_add(old_rec.reply, 32'd1);
    end
    if (is_fail && code != 32'd0) begin
      new_rec.acnt  = hpst_pkg::sat_add(old_rec.acnt, 32'd1);
      new_rec.acode = code;
    end
  end

endmodule

/* design/hpst_route_scan.sv */
`timescale 1ns / 1ps
// Route length scanner: walks the address memory once, one entry a cycle,
// tracking the first target match and the trailing run of equal addresses.
// Uses hpst_pkg.
module hpst_route_scan #(
  parameter int HOP_DEPTH = hpst_pkg::HOP_DEPTH_DEF,
  localparam int IDX_W = (HOP_DEPTH > 1) ? $clog2(HOP_DEPTH) : 1,
  localparam int CNT_W = $clog2(HOP_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [31:0]      target,
  output logic             rd_en,
  output logic [IDX_W-1:0] rd_idx,
  input  logic [31:0]      rd_data,
  output logic             done,
  output logic [CNT_W-1:0] route_len
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HOP_DEPTH - 1);

  logic             issuing;
  logic [IDX_W-1:0] cnt;
  logic             chk_valid;
  logic [IDX_W-1:0] chk_idx;
  logic             fin;
  logic             found;
  logic [IDX_W-1:0] match_idx;
  logic [IDX_W-1:0] run_start;
  logic [31:0]      prev;

  assign rd_en  = issuing;
  assign rd_idx = cnt;
  assign done   = fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing   <= 1'b0;
      chk_valid <= 1'b0;
      fin       <= 1'b0;
    end else begin
      chk_valid <= issuing;
      fin       <= chk_valid && (chk_idx == LAST_IDX);
      if (start) begin
        issuing <= 1'b1;
      end else if (issuing && cnt == LAST_IDX) begin
        issuing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt   <= '0;
      found <= 1'b0;
    end else begin
      if (issuing) begin
        cnt <= cnt + 1'b1;
      end
      if (chk_valid) begin
        if (!found && rd_data == target) begin
          found     <= 1'b1;
          match_idx <= chk_idx;
        end
        // a run continues while the address repeats and is nonzero
        if (chk_idx == '0 || rd_data != prev || rd_data == 32'd0) begin
          run_start <= chk_idx;
        end
        prev <= rd_data;
      end
    end
    chk_idx <= cnt;
  end

  always_comb begin
    if (found && match_idx != LAST_IDX) begin
      route_len = CNT_W'(match_idx) + 1'b1;
    end else begin
      route_len = CNT_W'(run_start) + 1'b1;
    end
  end

endmodule

/* design/hop_probe_statistics_table_core.sv */
`timescale 1ns / 1ps
// Hop probe statistics table, top level. Uses hpst_pkg, hpst_rec_mem,
// hpst_update and hpst_route_scan.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one item: func, hop, rtt_ms,
//   responder_addr, anomaly_code. Each item gives exactly one result on the
//   output channel (out_valid/out_ready): the hop's record after the update
//   plus route_length and farthest_alive.
//   cfg_valid/cfg_ready/cfg_data writes target_addr; cfg_ready is always high.
//   Items are handled one at a time. A reply to a hop inside the table also
//   runs the route rescan, which reads the address memory one entry a cycle,
//   before its result is loaded. in_ready returns at the edge that loads the
//   result, so a new item is taken only once the last one is through. A result
//   waiting on out_ready does not hold up the next item; only the loading of
//   its own result waits until the output register is free.
//   Reset (rst, synchronous) empties both memories through per-entry valid
//   bits and sets route length to HOP_DEPTH, farthest alive and target_addr
//   to zero. Clear-all does the same but keeps target_addr; clear-stats
//   empties only the stats memory.
module hop_probe_statistics_table_core #(
  parameter int HOP_DEPTH = hpst_pkg::HOP_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [4:0]  hop,
  input  logic [15:0] rtt_ms,
  input  logic [31:0] responder_addr,
  input  logic [31:0] anomaly_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hop_addr,
  output logic [31:0] sent_count,
  output logic [31:0] reply_count,
  output logic [15:0] best_rtt,
  output logic [15:0] worst_rtt,
  output logic [15:0] last_rtt,
  output logic [31:0] rtt_total,
  output logic [31:0] jitter_total,
  output logic [31:0] anomaly_count,
  output logic [31:0] anomaly_last,
  output logic [5:0]  route_length,
  output logic [5:0]  farthest_alive
);

  localparam int IDX_W = (HOP_DEPTH > 1) ? $clog2(HOP_DEPTH) : 1;
  localparam int CNT_W = $clog2(HOP_DEPTH + 1);
  localparam int REC_W = $bits(hpst_pkg::stats_t);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]  state;
  logic [31:0] target_addr;

  logic [2:0]  func_q;
  logic [4:0]  hop_q;
  logic [15:0] rtt_q;
  logic [31:0] resp_q;
  logic [31:0] code_q;

  logic             hop_ok;
  logic [IDX_W-1:0] hop_idx;
  logic [CNT_W-1:0] hop_plus1;
  logic             is_reply;
  logic             is_fail;

  logic [CNT_W-1:0] route_len;
  logic [CNT_W-1:0] alive;

  hpst_pkg::stats_t old_rec;
  hpst_pkg::stats_t new_rec;
  hpst_pkg::stats_t res_rec;
  logic [31:0]      res_addr;

  logic [REC_W-1:0] stats_rd;
  logic             stats_clr;
  logic             stats_wr_en;
  logic             addr_clr;
  logic             addr_wr_en;
  logic             addr_rd_en;
  logic [IDX_W-1:0] addr_rd_idx;
  logic [31:0]      addr_rd;

  logic             scan_start;
  logic             scan_rd_en;
  logic [IDX_W-1:0] scan_rd_idx;
  logic             scan_done;
  logic [CNT_W-1:0] scan_len;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  assign hop_ok    = ({27'd0, hop_q} < 32'(HOP_DEPTH));
  assign hop_idx   = IDX_W'(hop_q);
  assign hop_plus1 = CNT_W'({1'b0, hop_q} + 6'd1);
  assign is_reply  = hop_ok && (func_q == hpst_pkg::FUNC_REPLY);
  assign is_fail   = hop_ok && (func_q == hpst_pkg::FUNC_FAIL);

  assign old_rec = stats_rd;

  // clears act in the read cycle; the result mux forces their fields to zero
  assign stats_clr   = (state == S_READ) && (func_q == hpst_pkg::FUNC_CLR_STATS ||
                                             func_q == hpst_pkg::FUNC_CLR_ALL);
  assign addr_clr    = (state == S_READ) && (func_q == hpst_pkg::FUNC_CLR_ALL);
  assign stats_wr_en = (state == S_MOD) && (is_reply || is_fail);
  assign addr_wr_en  = (state == S_MOD) && is_reply && (addr_rd == 32'd0);
  assign scan_start  = (state == S_MOD) && is_reply;
  assign addr_rd_en  = (state == S_READ) || scan_rd_en;
  assign addr_rd_idx = (state == S_READ) ? hop_idx : scan_rd_idx;

  hpst_rec_mem #(
    .WIDTH (REC_W),
    .DEPTH (HOP_DEPTH)
  ) u_stats_mem (
    .clk     (clk),
    .rst     (rst),
    .clr     (stats_clr),
    .wr_en   (stats_wr_en),
    .wr_idx  (hop_idx),
    .wr_data (new_rec),
    .rd_en   (state == S_READ),
    .rd_idx  (hop_idx),
    .rd_data (stats_rd)
  );

  hpst_rec_mem #(
    .WIDTH (32),
    .DEPTH (HOP_DEPTH)
  ) u_addr_mem (
    .clk     (clk),
    .rst     (rst),
    .clr     (addr_clr),
    .wr_en   (addr_wr_en),
    .wr_idx  (hop_idx),
    .wr_data (resp_q),
    .rd_en   (addr_rd_en),
    .rd_idx  (addr_rd_idx),
    .rd_data (addr_rd)
  );

  hpst_update u_update (
    .is_reply (is_reply),
    .is_fail  (is_fail),
    .rtt      (rtt_q),
    .code     (code_q),
    .old_rec  (old_rec),
    .new_rec  (new_rec)
  );

  hpst_route_scan #(
    .HOP_DEPTH (HOP_DEPTH)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (scan_start),
    .target    (target_addr),
    .rd_en     (scan_rd_en),
    .rd_idx    (scan_rd_idx),
    .rd_data   (addr_rd),
    .done      (scan_done),
    .route_len (scan_len)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      target_addr <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      target_addr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_q <= func;
      hop_q  <= hop;
      rtt_q  <= rtt_ms;
      resp_q <= responder_addr;
      code_q <= anomaly_code;
    end
  end

  // result record of the item, captured once the read data is back
  always_ff @(posedge clk) begin
    if (state == S_MOD) begin
      if (!hop_ok) begin
        res_rec  <= '0;
        res_addr <= 32'd0;
      end else begin
        case (func_q)
          hpst_pkg::FUNC_REPLY: begin
            res_rec  <= new_rec;
            res_addr <= (addr_rd == 32'd0) ? resp_q : addr_rd;
          end
          hpst_pkg::FUNC_FAIL: begin
            res_rec  <= new_rec;
            res_addr <= addr_rd;
          end
          hpst_pkg::FUNC_READ: begin
            res_rec  <= old_rec;
            res_addr <= addr_rd;
          end
          hpst_pkg::FUNC_CLR_STATS: begin
            res_rec  <= '0;
            res_addr <= addr_rd;
          end
          hpst_pkg::FUNC_CLR_ALL: begin
            res_rec  <= '0;
            res_addr <= 32'd0;
          end
          default: begin
            res_rec  <= old_rec;
            res_addr <= addr_rd;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      route_len <= CNT_W'(HOP_DEPTH);
      alive     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (func_q == hpst_pkg::FUNC_CLR_ALL) begin
            route_len <= CNT_W'(HOP_DEPTH);
            alive     <= '0;
          end
          state <= S_MOD;
        end
        S_MOD: begin
          if (is_reply && hop_plus1 > alive) begin
            alive <= hop_plus1;
          end
          state <= is_reply ? S_SCAN : S_OUT;
        end
        S_SCAN: begin
          if (scan_done) begin
            route_len <= scan_len;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || out_ready)) begin
      hop_addr       <= res_addr;
      sent_count     <= res_rec.sent;
      reply_count    <= res_rec.reply;
      best_rtt       <= res_rec.best;
      worst_rtt      <= res_rec.worst;
      last_rtt       <= res_rec.last;
      rtt_total      <= res_rec.total;
      jitter_total   <= res_rec.jitter;
      anomaly_count  <= res_rec.acnt;
      anomaly_last   <= res_rec.acode;
      route_length   <= 6'(route_len);
      farthest_alive <= 6'(alive);
    end
  end

  a_route_bound: assert property (@(posedge clk) disable iff (rst)
    route_len <= CNT_W'(HOP_DEPTH))
    else $error("route length beyond table depth");

  a_alive_bound: assert property (@(posedge clk) disable iff (rst)
    alive <= CNT_W'(HOP_DEPTH))
    else $error("farthest alive beyond table depth");

  a_scan_done_state: assert property (@(posedge clk) disable iff (rst)
    scan_done |-> state == S_SCAN)
    else $error("scan finished outside the scan state");

  a_write_state: assert property (@(posedge clk) disable iff (rst)
    (stats_wr_en || addr_wr_en) |-> state == S_MOD)
    else $error("memory write outside the modify state");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken while one is in progress");

endmodule

/* tb/hop_probe_statistics_table_core_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for hop_probe_statistics_table_core: directed items, then
// traceroute-like rounds under several target addresses, checked against a local mirror.
// Depends on hpst_pkg and the core RTL.
module hop_probe_statistics_table_core_test;

  localparam int HOPS = hpst_pkg::HOP_DEPTH_DEF;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 290;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
  localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [2:0]  func;
    logic [4:0]  hop;
    logic [15:0] rtt;
    logic [31:0] responder;
    logic [31:0] code;
  } probe_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] sent;
    logic [31:0] replies;
    logic [15:0] best;
    logic [15:0] worst;
    logic [15:0] last;
    logic [31:0] total;
    logic [31:0] jitter;
    logic [31:0] anom_cnt;
    logic [31:0] anom_code;
    logic [5:0]  route_len;
    logic [5:0]  alive;
  } hop_view_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  func = '0;
  logic [4:0]  hop = '0;
  logic [15:0] rtt_ms = '0;
  logic [31:0] responder_addr = '0;
  logic [31:0] anomaly_code = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] hop_addr;
  logic [31:0] sent_count;
  logic [31:0] reply_count;
  logic [15:0] best_rtt;
  logic [15:0] worst_rtt;
  logic [15:0] last_rtt;
  logic [31:0] rtt_total;
  logic [31:0] jitter_total;
  logic [31:0] anomaly_count;
  logic [31:0] anomaly_last;
  logic [5:0]  route_length;
  logic [5:0]  farthest_alive;

  hop_probe_statistics_table_core i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .hop(hop), .rtt_ms(rtt_ms),
    .responder_addr(responder_addr), .anomaly_code(anomaly_code),
    .out_valid(out_valid), .out_ready(out_ready),
    .hop_addr(hop_addr), .sent_count(sent_count), .reply_count(reply_count),
    .best_rtt(best_rtt), .worst_rtt(worst_rtt), .last_rtt(last_rtt),
    .rtt_total(rtt_total), .jitter_total(jitter_total),
    .anomaly_count(anomaly_count), .anomaly_last(anomaly_last),
    .route_length(route_length), .farthest_alive(farthest_alive)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mirror of the hop table
  hpst_pkg::stats_t hop_stats [HOPS];
  logic [31:0] hop_addrs [HOPS];
  logic [5:0]  route_len_m;
  logic [5:0]  alive_m;
  logic [31:0] target_m;

  probe_t      pending_probes [$];
  hop_view_t   expected_views [$];
  int unsigned probes_queued = 0;
  int unsigned probes_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  logic        calm = 1'b0;

  function automatic logic [31:0] bump32(logic [31:0] a, logic [31:0] b);
    return (a > 32'hFFFF_FFFF - b) ? 32'hFFFF_FFFF : a + b;
  endfunction

  function automatic void wipe_stats();
    for (int i = 0; i < HOPS; i++) hop_stats[i] = '0;
  endfunction

  function automatic void forget_route();
    wipe_stats();
    for (int i = 0; i < HOPS; i++) hop_addrs[i] = '0;
    route_len_m = 6'(HOPS);
    alive_m = '0;
  endfunction

  // Applies one probe outcome to the mirror and returns the hop view it should report.
  function automatic hop_view_t advance_hop_table(probe_t p);
    hop_view_t   v;
    int          h;
    int          n;
    logic        found;
    logic [15:0] delta;
    h = int'(p.hop);
    case (p.func)
      hpst_pkg::FUNC_REPLY: begin
        hop_stats[h].sent = bump32(hop_stats[h].sent, 32'd1);
        if (hop_stats[h].reply != 0) begin
          delta = (p.rtt > hop_stats[h].last) ? p.rtt - hop_stats[h].last
                                              : hop_stats[h].last - p.rtt;
          hop_stats[h].jitter = bump32(hop_stats[h].jitter, {16'd0, delta});
        end
        hop_stats[h].last = p.rtt;
        hop_stats[h].total = bump32(hop_stats[h].total, {16'd0, p.rtt});
        if (hop_stats[h].reply == 0 || hop_stats[h].best > p.rtt) hop_stats[h].best = p.rtt;
        if (hop_stats[h].worst < p.rtt) hop_stats[h].worst = p.rtt;
        hop_stats[h].reply = bump32(hop_stats[h].reply, 32'd1);
        if (h + 1 > alive_m) alive_m = 6'(h + 1);
        if (hop_addrs[h] == '0) hop_addrs[h] = p.responder;
        // route length: first hop holding the target, else full depth less repeated tail
        found = 1'b0;
        n = HOPS;
        for (int i = 0; i < HOPS; i++) begin
          if (!found && hop_addrs[i] == target_m) begin
            found = 1'b1;
            n = i + 1;
          end
        end
        if (n == HOPS) begin
          while (n > 1 && hop_addrs[n-1] == hop_addrs[n-2] && hop_addrs[n-1] != '0) n--;
        end
        route_len_m = 6'(n);
      end
      hpst_pkg::FUNC_FAIL: begin
        hop_stats[h].sent = bump32(hop_stats[h].sent, 32'd1);
        if (p.code != '0) begin
          hop_stats[h].acnt = bump32(hop_stats[h].acnt, 32'd1);
          hop_stats[h].acode = p.code;
        end
      end
      hpst_pkg::FUNC_CLR_STATS: wipe_stats();
      hpst_pkg::FUNC_CLR_ALL: forget_route();
      default: ;
    endcase
    v.addr      = hop_addrs[h];
    v.sent      = hop_stats[h].sent;
    v.replies   = hop_stats[h].reply;
    v.best      = hop_stats[h].best;
    v.worst     = hop_stats[h].worst;
    v.last      = hop_stats[h].last;
    v.total     = hop_stats[h].total;
    v.jitter    = hop_stats[h].jitter;
    v.anom_cnt  = hop_stats[h].acnt;
    v.anom_code = hop_stats[h].acode;
    v.route_len = route_len_m;
    v.alive     = alive_m;
    return v;
  endfunction

  function automatic void check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Driver
  probe_t      cur_probe;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        expected_views.push_back(advance_hop_table(cur_probe));
        probes_accepted++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        gap_left = $urandom_range(0, 9);
        in_valid <= 1'b0;
      end else if (pending_probes.size() > 0) begin
        cur_probe = pending_probes.pop_front();
        func <= cur_probe.func;
        hop <= cur_probe.hop;
        rtt_ms <= cur_probe.rtt;
        responder_addr <= cur_probe.responder;
        anomaly_code <= cur_probe.code;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor
  hop_view_t   got_view;
  hop_view_t   want_view;
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_view = {hop_addr, sent_count, reply_count, best_rtt, worst_rtt, last_rtt,
                    rtt_total, jitter_total, anomaly_count, anomaly_last,
                    route_length, farthest_alive};
        if (expected_views.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, got_view);
          mismatches++;
        end else begin
          want_view = expected_views.pop_front();
          check_field("hop_addr", got_view.addr, want_view.addr);
          check_field("sent_count", got_view.sent, want_view.sent);
          check_field("reply_count", got_view.replies, want_view.replies);
          check_field("best_rtt", {16'd0, got_view.best}, {16'd0, want_view.best});
          check_field("worst_rtt", {16'd0, got_view.worst}, {16'd0, want_view.worst});
          check_field("last_rtt", {16'd0, got_view.last}, {16'd0, want_view.last});
          check_field("rtt_total", got_view.total, want_view.total);
          check_field("jitter_total", got_view.jitter, want_view.jitter);
          check_field("anomaly_count", got_view.anom_cnt, want_view.anom_cnt);
          check_field("anomaly_last", got_view.anom_code, want_view.anom_code);
          check_field("route_length", {26'd0, got_view.route_len},
                      {26'd0, want_view.route_len});
          check_field("farthest_alive", {26'd0, got_view.alive}, {26'd0, want_view.alive});
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // r carries the RTT in its low 16 bits
  task automatic queue_probe(logic [2:0] f, int unsigned h, logic [31:0] r,
                             logic [31:0] a, logic [31:0] c);
    probe_t p;
    p.func = f;
    p.hop = 5'(h);
    p.rtt = r[15:0];
    p.responder = a;
    p.code = c;
    pending_probes.push_back(p);
    probes_queued++;
  endtask

  function automatic logic [31:0] pick_rtt();
    int unsigned roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return 32'd0;
    if (roll == 1) return 32'h0000_FFFF;
    if (roll < 4) return $urandom & 32'h0000_FFFF;
    return $urandom_range(1, 300);
  endfunction

  // Waits until every item is accepted and answered, then lets the rescan run out.
  task automatic settle();
    while (probes_accepted != probes_queued || expected_views.size() != 0) @(posedge clk);
    repeat (HOPS + 8) @(posedge clk);
  endtask

  task automatic write_target(logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    target_m = value;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] path_addr [HOPS];
    logic [31:0] dest;
    logic [31:0] tgt;
    int unsigned depth;
    int unsigned goal;
    int unsigned mode;
    int unsigned hh;
    int unsigned roll;
    logic        scattered;
    forget_route();
    target_m = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, spare codes, extremes, kept address, failures, clears
    queue_probe(hpst_pkg::FUNC_READ, 0, $urandom, $urandom, $urandom);
    queue_probe(FUNC_SPARE_FIRST, 31, $urandom, $urandom, $urandom);
    queue_probe(FUNC_SPARE_FIRST + 3'd1, 7, $urandom, $urandom, $urandom);
    queue_probe(FUNC_SPARE_LAST, 0, $urandom, $urandom, $urandom);
    queue_probe(hpst_pkg::FUNC_REPLY, 0, 32'd0, 32'd0, 32'd0);  // empty hop matches zero target
    queue_probe(hpst_pkg::FUNC_REPLY, 31, 32'h0000_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_probe(hpst_pkg::FUNC_REPLY, 31, 32'd0, 32'h0A00_0001, 32'd0);  // address kept
    queue_probe(hpst_pkg::FUNC_REPLY, 31, 32'h0000_FFFF, 32'd0, 32'd0);
    queue_probe(hpst_pkg::FUNC_REPLY, 0, 32'd40, 32'hC0A8_0001, 32'd0);
    queue_probe(hpst_pkg::FUNC_REPLY, 1, 32'd30, 32'hC0A8_0001, 32'd0);
    queue_probe(hpst_pkg::FUNC_REPLY, 1, 32'd90, 32'h0808_0808, 32'd0);
    queue_probe(hpst_pkg::FUNC_FAIL, 2, $urandom, $urandom, 32'd0);      // plain timeout
    queue_probe(hpst_pkg::FUNC_FAIL, 2, $urandom, $urandom, 32'hFFFF_FFFF);
    queue_probe(hpst_pkg::FUNC_FAIL, 2, $urandom, $urandom, 32'd1);
    queue_probe(hpst_pkg::FUNC_READ, 2, $urandom, $urandom, $urandom);
    queue_probe(hpst_pkg::FUNC_CLR_STATS, 5, $urandom, $urandom, $urandom);
    queue_probe(hpst_pkg::FUNC_READ, 31, $urandom, $urandom, $urandom);
    queue_probe(hpst_pkg::FUNC_READ, 0, $urandom, $urandom, $urandom);
    queue_probe(hpst_pkg::FUNC_REPLY, 5, 32'd7, $urandom, $urandom);
    queue_probe(hpst_pkg::FUNC_CLR_ALL, 5, $urandom, $urandom, $urandom);
    queue_probe(hpst_pkg::FUNC_READ, 5, $urandom, $urandom, $urandom);
    queue_probe(hpst_pkg::FUNC_READ, 31, $urandom, $urandom, $urandom);
    settle();

    // Trace rounds: destination answers every hop from depth-1 on, some routers stay silent
    for (int p = 0; p < PHASES; p++) begin
      mode = p % 4;
      depth = $urandom_range(2, HOPS);
      dest = (mode == 3) ? 32'hFFFF_FFFF : $urandom;
      for (int h = 0; h < HOPS; h++) begin
        if (h >= depth - 1) path_addr[h] = dest;
        else path_addr[h] = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom;
      end
      case (mode)
        0: tgt = dest;
        1: tgt = $urandom;
        2: tgt = 32'd0;
        default: tgt = 32'hFFFF_FFFF;
      endcase
      if (p == PHASES - 1) calm = 1'b1;
      write_target(tgt);
      // route length stays stale until the next reply
      queue_probe(hpst_pkg::FUNC_READ, 0, $urandom, $urandom, $urandom);
      goal = probes_queued + PHASE_ITEMS;
      while (probes_queued < goal) begin
        scattered = ($urandom_range(0, 9) == 0);
        for (int h = 0; h < HOPS; h++) begin
          hh = scattered ? $urandom_range(0, HOPS - 1) : h;
          roll = $urandom_range(0, 999);
          if (roll < 40)
            queue_probe(hpst_pkg::FUNC_READ, $urandom_range(0, HOPS - 1), $urandom,
                        $urandom, $urandom);
          else if (roll < 50)
            queue_probe(3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST)),
                        $urandom_range(0, HOPS - 1), $urandom, $urandom, $urandom);
          else if (roll < 55)
            queue_probe(hpst_pkg::FUNC_CLR_STATS, $urandom_range(0, HOPS - 1), $urandom,
                        $urandom, $urandom);
          else if (roll < 58)
            queue_probe(hpst_pkg::FUNC_CLR_ALL, $urandom_range(0, HOPS - 1), $urandom,
                        $urandom, $urandom);
          if (path_addr[hh] != 32'd0 && $urandom_range(0, 3) != 0)
            queue_probe(hpst_pkg::FUNC_REPLY, hh, pick_rtt(),
                        ($urandom_range(0, 19) == 0) ? $urandom : path_addr[hh], $urandom);
          else
            queue_probe(hpst_pkg::FUNC_FAIL, hh, $urandom, $urandom,
                        ($urandom_range(0, 2) == 0) ? $urandom : 32'd0);
        end
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/hpst_pkg.sv
design/hpst_rec_mem.sv
design/hpst_update.sv
design/hpst_route_scan.sv
design/hop_probe_statistics_table_core.sv
tb/hop_probe_statistics_table_core_test.sv
